/* hw/rtl/ctbp_pkg.sv */
// ----------------------------------------------------------------------------
// ctbp_pkg
// Shared types and constants of the backprojection accumulator: word layout,
// action codes, default sizes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ctbp_pkg;

	// default sizes
	localparam int IMAGE_SIZE_DEF = 64;
	localparam int NUM_ANGLES_DEF = 180;
	localparam int ACC_WIDTH_DEF  = 24;

	// field widths
	localparam int ANGLE_W  = 8;
	localparam int DET_W    = 6;
	localparam int SAMPLE_W = 17;
	localparam int PIX_W    = 6;
	localparam int SUM_W    = 24;
	localparam int ACTION_W = 2;

	// input tdata layout, lowest field first
	localparam int ANGLE_LSB  = 0;
	localparam int DET_LSB    = ANGLE_LSB + ANGLE_W;
	localparam int SAMPLE_LSB = DET_LSB + DET_W;
	localparam int PX_LSB     = SAMPLE_LSB + SAMPLE_W;
	localparam int PY_LSB     = PX_LSB + PIX_W;
	localparam int IN_BITS    = PY_LSB + PIX_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;

	localparam int ANGLE_CODES = 1 << ANGLE_W;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic take_item;
		logic buf_wr;
		logic pass_init;
		logic pass_adv;
		logic cnt_clr;
		logic cnt_adv;
		logic clear_wr;
		logic read_sel;
		logic out_ld;
	} ctbp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    last;
		logic    last_pix;
		logic    pipe_busy;
		logic    out_busy;
	} ctbp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ct_backprojection_accumulator.sv */
// ----------------------------------------------------------------------------
// ct_backprojection_accumulator
// Unfiltered parallel-beam backprojection with linear detector interpolation.
// ----------------------------------------------------------------------------
// Words are taken one at a time. A load word writes one detector sample;
// a load word with tlast set then sweeps the whole image at one pixel per
// cycle, limited by the single read port and single write port of the
// accumulator memory. A read word waits for the result register to empty;
// a clear word sweeps zeros through every pixel of the accumulator memory,
// as the block also does after reset, with s_tready low. Detector samples
// never written since reset must not be used by a pass.
`default_nettype none

module ct_backprojection_accumulator #(
	parameter int IMAGE_SIZE = ctbp_pkg::IMAGE_SIZE_DEF,
	parameter int NUM_ANGLES = ctbp_pkg::NUM_ANGLES_DEF,
	parameter int ACC_WIDTH  = ctbp_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// angle_index, detector_index, sample_value, pixel_x, pixel_y, zero pad
	input  wire logic [ctbp_pkg::IN_TDATA_W-1:0]   s_tdata,
	// action
	input  wire logic [ctbp_pkg::ACTION_W-1:0]     s_tuser,
	// last_of_column
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pixel_sum
	output logic [ctbp_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	ctbp_pkg::ctbp_cmd_t cmd;
	ctbp_pkg::ctbp_sts_t sts;

	ctbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ctbp_datapath #(
		.IMAGE_SIZE (IMAGE_SIZE),
		.NUM_ANGLES (NUM_ANGLES),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a new word is never taken while pixels are still in flight
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sts.pipe_busy)
		else $error("word accepted with pixel pipeline busy");

	// the clear sweep must not collide with pipeline write-back
	a_clear_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_wr |-> !sts.pipe_busy)
		else $error("clear sweep overlaps pixel pass");

	// a column-closing load starts a pixel pass
	a_pass_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast && (s_tuser == ctbp_pkg::ACT_LOAD))
		|-> ##4 sts.pipe_busy)
		else $error("column-closing load did not start a pass");

endmodule

`default_nettype wire

/* hw/rtl/ctbp_ctrl.sv */
// ----------------------------------------------------------------------------
// ctbp_ctrl
// Sequencer: decodes each word, runs the image clear sweep, the pixel pass
// and the pixel read, and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output ctbp_pkg::ctbp_cmd_t       cmd,
	input  wire ctbp_pkg::ctbp_sts_t  sts
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_DECODE = 7'b0000100,
		ST_SETUP  = 7'b0001000,
		ST_PASS   = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.cnt_adv  = 1'b1;
				if (sts.last_pix) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.take_item = s_tvalid;
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (sts.action)
					ctbp_pkg::ACT_LOAD: begin
						cmd.buf_wr = 1'b1;
						state_d    = sts.last ? ST_SETUP : ST_IDLE;
					end
					ctbp_pkg::ACT_READ: begin
						cmd.read_sel = 1'b1;
						state_d      = ST_RESULT;
					end
					ctbp_pkg::ACT_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_CLEAR;
					end
					default: begin
						// unused action code: drop the word
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SETUP: begin
				cmd.pass_init = 1'b1;
				cmd.cnt_clr   = 1'b1;
				state_d       = ST_PASS;
			end
			ST_PASS: begin
				cmd.pass_adv = 1'b1;
				cmd.cnt_adv  = 1'b1;
				if (sts.last_pix) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_IDLE;
			end
			ST_RESULT: begin
				cmd.read_sel = 1'b1;
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/ctbp_datapath.sv */
// ----------------------------------------------------------------------------
// ctbp_datapath
// Word capture, column buffer, trig table, incremental detector position,
// interpolation pipeline, image accumulator memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctbp_datapath #(
	parameter int IMAGE_SIZE = ctbp_pkg::IMAGE_SIZE_DEF,
	parameter int NUM_ANGLES = ctbp_pkg::NUM_ANGLES_DEF,
	parameter int ACC_WIDTH  = ctbp_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ctbp_pkg::ctbp_cmd_t                cmd,
	output ctbp_pkg::ctbp_sts_t                     sts,
	input  wire logic [ctbp_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  wire logic [ctbp_pkg::ACTION_W-1:0]      s_tuser,
	input  wire logic                               s_tlast,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [ctbp_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	localparam int BAW  = $clog2(IMAGE_SIZE);
	localparam int NPIX = IMAGE_SIZE * IMAGE_SIZE;
	localparam int PAW  = $clog2(NPIX);
	localparam int DW   = BAW + 17;
	localparam int IW   = DW - 15;
	localparam int SW   = ctbp_pkg::SAMPLE_W;

	localparam logic [PAW-1:0]       LAST_PIX = PAW'(NPIX - 1);
	localparam logic [BAW-1:0]       LAST_X   = BAW'(IMAGE_SIZE - 1);
	localparam logic signed [DW-1:0] D_N      = DW'(IMAGE_SIZE);
	localparam logic signed [IW:0]   I_N      = (IW + 1)'(IMAGE_SIZE);

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// sin(x) for 0 <= x <= pi/2, Q30 in and out
	function automatic logic [63:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] h;
		x2 = (x * x) >> 30;
		h  = Q30_ONE;
		for (int i = 0; i < 6; i++) begin
			h = Q30_ONE - (((x2 * h) >> 30) / TAYLOR_DIV[i]);
		end
		return (x * h) >> 30;
	endfunction

	function automatic logic [15:0] q30_to_q14(input logic [63:0] s);
		logic [63:0] v;
		v = (s + 64'd32768) >> 16;
		if (v > 64'd16384) v = 64'd16384;
		return v[15:0];
	endfunction

	// {cos, sin} in Q2.14 for an angle code, folded modulo the angle count
	function automatic logic [31:0] trig_entry(input int idx);
		logic [63:0] k;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [15:0] s;
		logic [15:0] c;
		logic [15:0] sn;
		logic [15:0] cs;
		k = 64'(idx % NUM_ANGLES);
		q = (64'd4 * k) / NUM_ANGLES;
		r = 64'd4 * k - q * NUM_ANGLES;
		x = (r * HALF_PI_Q30) / NUM_ANGLES;
		s = q30_to_q14(sine_q30(x));
		c = q30_to_q14(sine_q30(HALF_PI_Q30 - x));
		unique case (q[1:0])
			2'd0: begin sn = s;  cs = c;  end
			2'd1: begin sn = c;  cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
		return {cs, sn};
	endfunction

	// ---------------- word capture ----------------
	ctbp_pkg::action_t            action_q;
	logic                         last_q;
	logic [ctbp_pkg::ANGLE_W-1:0] angle_q;
	logic [ctbp_pkg::DET_W-1:0]   det_q;
	logic [SW-1:0]                sample_q;
	logic [ctbp_pkg::PIX_W-1:0]   px_q;
	logic [ctbp_pkg::PIX_W-1:0]   py_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			action_q <= ctbp_pkg::action_t'(s_tuser);
			last_q   <= s_tlast;
			angle_q  <= s_tdata[ctbp_pkg::ANGLE_LSB +: ctbp_pkg::ANGLE_W];
			det_q    <= s_tdata[ctbp_pkg::DET_LSB +: ctbp_pkg::DET_W];
			sample_q <= s_tdata[ctbp_pkg::SAMPLE_LSB +: SW];
			px_q     <= s_tdata[ctbp_pkg::PX_LSB +: ctbp_pkg::PIX_W];
			py_q     <= s_tdata[ctbp_pkg::PY_LSB +: ctbp_pkg::PIX_W];
		end
	end

	// ---------------- trig table ----------------
	logic [31:0]        trig_rom [ctbp_pkg::ANGLE_CODES];
	logic signed [15:0] sn_q;
	logic signed [15:0] cs_q;

	for (genvar g = 0; g < ctbp_pkg::ANGLE_CODES; g++) begin : g_trig
		localparam logic [31:0] ENTRY = trig_entry(g);
		assign trig_rom[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		{cs_q, sn_q} <= trig_rom[angle_q];
	end

	// ---------------- pixel / sweep counters ----------------
	logic [PAW-1:0] pix_q;
	logic [BAW-1:0] x_q;
	logic           row_end;

	assign row_end = (x_q == LAST_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			x_q   <= '0;
		end else if (cmd.cnt_clr) begin
			pix_q <= '0;
			x_q   <= '0;
		end else if (cmd.cnt_adv) begin
			pix_q <= pix_q + PAW'(1);
			x_q   <= row_end ? '0 : x_q + BAW'(1);
		end
	end

	// ---------------- detector position, stepped per pixel ----------------
	logic signed [DW-1:0] d_q, row_q, dx_q, dy_q;
	logic signed [DW-1:0] sn_ext, cs_ext, init_base, d_init;

	always_comb begin
		sn_ext    = DW'(sn_q);
		cs_ext    = DW'(cs_q);
		init_base = sn_ext - cs_ext + DW'(16384);
		d_init    = init_base * D_N;
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			d_q   <= d_init;
			row_q <= d_init;
			dx_q  <= -(sn_ext <<< 1);
			dy_q  <= cs_ext <<< 1;
		end else if (cmd.pass_adv) begin
			if (row_end) begin
				d_q   <= row_q + dy_q;
				row_q <= row_q + dy_q;
			end else begin
				d_q <= d_q + dx_q;
			end
		end
	end

	// neighbour indexes: floor of the Q.15 position and the next bin
	logic signed [IW-1:0] i0;
	logic signed [IW:0]   i0_ext, i1;
	logic                 in0, in1;
	logic [BAW-1:0]       ra0, ra1;

	always_comb begin
		i0     = d_q[DW-1:15];
		i0_ext = {i0[IW-1], i0};
		i1     = i0_ext + (IW + 1)'(1);
		in0    = !i0_ext[IW] && (i0_ext < I_N);
		in1    = !i1[IW] && (i1 < I_N);
		ra0    = i0[BAW-1:0];
		ra1    = i1[BAW-1:0];
	end

	// ---------------- column buffer ----------------
	logic [SW-1:0]              colbuf [IMAGE_SIZE];
	logic [BAW+ctbp_pkg::DET_W-1:0] det_ext;
	logic                       det_ok;

	assign det_ext = {{BAW{1'b0}}, det_q};
	assign det_ok  = (32'(det_q) < IMAGE_SIZE);

	logic [SW-1:0]  v0_s1, v1_s1;
	logic [14:0]    w1_s1;
	logic           in0_s1, both_s1, any_s1, vld_s1;
	logic [PAW-1:0] addr_s1;

	always_ff @(posedge clk) begin
		if (cmd.buf_wr && det_ok) colbuf[det_ext[BAW-1:0]] <= sample_q;
		v0_s1   <= colbuf[ra0];
		v1_s1   <= colbuf[ra1];
		w1_s1   <= d_q[14:0];
		in0_s1  <= in0;
		both_s1 <= in0 && in1;
		any_s1  <= in0 || in1;
		addr_s1 <= pix_q;
	end

	// ---------------- interpolation ----------------
	logic signed [SW:0]   diff;
	logic signed [SW+16:0] prod;

	assign diff = $signed({1'b0, v1_s1}) - $signed({1'b0, v0_s1});
	assign prod = $signed({1'b0, w1_s1}) * diff;

	logic signed [SW+16:0] prod_s2;
	logic [SW-1:0]         base_s2;
	logic                  both_s2, any_s2, vld_s2;
	logic [PAW-1:0]        addr_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		base_s2 <= in0_s1 ? v0_s1 : v1_s1;
		both_s2 <= both_s1;
		any_s2  <= any_s1;
		addr_s2 <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.pass_adv;
			vld_s2 <= vld_s1;
		end
	end

	// v0 + round(w1 * (v1 - v0) / 2^15) equals the two-weight blend exactly
	logic signed [SW+16:0]    rnd;
	logic signed [SW+1:0]     corr, val_w;
	logic [SW-1:0]            val;
	logic [ACC_WIDTH:0]       sum;
	logic [ACC_WIDTH-1:0]     acc_rd_q, acc_new;

	always_comb begin
		rnd     = prod_s2 + (SW + 17)'(16384);
		corr    = rnd[SW+16:15];
		val_w   = $signed({2'b00, base_s2}) + (both_s2 ? corr : '0);
		val     = val_w[SW-1:0];
		sum     = {1'b0, acc_rd_q} + (ACC_WIDTH + 1)'(val);
		acc_new = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
	end

	// ---------------- image accumulator memory ----------------
	logic [ACC_WIDTH-1:0] accmem [NPIX];
	logic [PAW-1:0]       rd_addr, acc_ra, acc_wa;
	logic [ACC_WIDTH-1:0] acc_wd;
	logic                 acc_we, rd_in;

	assign rd_in   = (32'(px_q) < IMAGE_SIZE) && (32'(py_q) < IMAGE_SIZE);
	assign rd_addr = PAW'(32'(py_q) * IMAGE_SIZE + 32'(px_q));
	assign acc_ra  = cmd.read_sel ? rd_addr : addr_s1;
	assign acc_wa  = cmd.clear_wr ? pix_q : addr_s2;
	assign acc_wd  = cmd.clear_wr ? '0 : acc_new;
	assign acc_we  = cmd.clear_wr || (vld_s2 && any_s2);

	always_ff @(posedge clk) begin
		if (acc_we) accmem[acc_wa] <= acc_wd;
		acc_rd_q <= accmem[acc_ra];
	end

	// ---------------- result register ----------------
	localparam int XW = ACC_WIDTH + ctbp_pkg::SUM_W;

	logic [XW-1:0]                acc_x;
	logic [ctbp_pkg::SUM_W-1:0]   sum_sat;
	logic [ctbp_pkg::SUM_W-1:0]   out_q;
	logic                         out_vld_q;

	always_comb begin
		acc_x   = XW'(acc_rd_q);
		sum_sat = (acc_x > XW'(ctbp_pkg::SUM_MAX)) ? ctbp_pkg::SUM_MAX
			: acc_x[ctbp_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) out_q <= rd_in ? sum_sat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = ctbp_pkg::OUT_TDATA_W'(out_q);

	// ---------------- status ----------------
	always_comb begin
		sts.action    = action_q;
		sts.last      = last_q;
		sts.last_pix  = (pix_q == LAST_PIX);
		sts.pipe_busy = vld_s1 || vld_s2;
		sts.out_busy  = out_vld_q && !m_tready;
	end

endmodule

`default_nettype wire

/* tb/tb_ct_backprojection_accumulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ct_backprojection_accumulator
// Self-checking bench for the backprojection accumulator. An initial block
// queues load, read, clear and unused-code words: directed corner cases, a
// saturation run of 256 full-scale sweeps and mixed random traffic under
// three pacing schemes. A clocked driver offers the queued words. Each word
// the block takes updates a local image model: Q2.14 trig table, linear
// detector interpolation and saturating pixel sums. Each read pushes the
// pixel_sum it should return. A clocked monitor checks every result word
// against the oldest pending sum.
// ----------------------------------------------------------------------------

module tb_ct_backprojection_accumulator;
	import ctbp_pkg::*;

	localparam int GRID = IMAGE_SIZE_DEF;
	localparam int ANGLES = NUM_ANGLES_DEF;
	localparam longint unsigned ACC_CEIL = (64'd1 << ACC_WIDTH_DEF) - 64'd1;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int SAMPLE_ONE = 65536;
	localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 4200;
	localparam int CYCLE_LIMIT = 8000000;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ANGLE_W-1:0]  angle;
		logic [DET_W-1:0]    det;
		logic [SAMPLE_W-1:0] sample;
		logic                last;
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
	} bp_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [ACTION_W-1:0]    s_tuser = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// image model
	int              sin_q14 [ANGLES];
	int              cos_q14 [ANGLES];
	int unsigned     detector_bins [GRID];
	longint unsigned image_sums [GRID*GRID];
	logic [SUM_W-1:0] expected_sums [$];

	bp_word_t pending_words [$];
	bp_word_t offered;
	int words_queued = 0;
	int words_accepted = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int cycles_run = 0;

	ct_backprojection_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sin(x) on [0, pi/2], Q30 in and out
	function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
		longint unsigned x2, h;
		int i;
		x2 = (x * x) >> 30;
		h = Q30_ONE;
		// nested Taylor terms, divisors n*(n-1) for n = 13, 11, ... 3
		for (i = 0; i < 6; i++)
			h = Q30_ONE - ((x2 * h) >> 30) / longint'((13 - 2 * i) * (12 - 2 * i));
		return (x * h) >> 30;
	endfunction

	function automatic int round_to_q14(input longint unsigned s);
		longint unsigned v;
		v = (s + 64'd32768) >> 16;
		if (v > 64'd16384)
			v = 64'd16384;
		return int'(v);
	endfunction

	function automatic void backproject_column(input int angle);
		longint n, sn, cs, d, i0, i1, w0, w1, val;
		int x, y, idx;
		bit hit;
		n = GRID;
		sn = sin_q14[angle];
		cs = cos_q14[angle];
		for (y = 0; y < GRID; y++) begin
			for (x = 0; x < GRID; x++) begin
				d = -(2 * longint'(x) - n) * sn + (2 * longint'(y) - n) * cs + n * 16384;
				i0 = d >>> 15;
				i1 = i0 + 1;
				w1 = d - i0 * 32768;
				w0 = 32768 - w1;
				hit = 1'b1;
				if (i0 >= 0 && i1 < n)
					val = (w0 * detector_bins[i0] + w1 * detector_bins[i1] + 16384) >> 15;
				else if (i0 >= 0 && i0 < n)
					val = detector_bins[i0];
				else if (i1 >= 0 && i1 < n)
					val = detector_bins[i1];
				else
					hit = 1'b0;
				if (hit) begin
					idx = y * GRID + x;
					if (val >= ACC_CEIL - image_sums[idx])
						image_sums[idx] = ACC_CEIL;
					else
						image_sums[idx] = image_sums[idx] + val;
				end
			end
		end
	endfunction

	function automatic void apply_to_image(input bp_word_t w);
		longint unsigned v;
		int i;
		case (w.action)
			ACT_LOAD: begin
				detector_bins[w.det] = w.sample;
				if (w.last)
					backproject_column(int'(w.angle) % ANGLES);
			end
			ACT_READ: begin
				v = image_sums[int'(w.py) * GRID + int'(w.px)];
				if (v > SUM_MAX)
					v = SUM_MAX;
				expected_sums.push_back(v[SUM_W-1:0]);
			end
			ACT_CLEAR: begin
				for (i = 0; i < GRID * GRID; i++)
					image_sums[i] = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		$display("%0t ns: %s: pixel_sum %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_word(input logic [ACTION_W-1:0] act, input int angle, input int det,
			input int sample, input bit last, input int px, input int py);
		bp_word_t w;
		w.action = act;
		w.angle = angle[ANGLE_W-1:0];
		w.det = det[DET_W-1:0];
		w.sample = sample[SAMPLE_W-1:0];
		w.last = last;
		w.px = px[PIX_W-1:0];
		w.py = py[PIX_W-1:0];
		pending_words.push_back(w);
		words_queued++;
	endtask

	function automatic int pick_sample();
		case ($urandom_range(7))
			0: return 0;
			1: return SAMPLE_ONE;
			default: return $urandom_range(SAMPLE_ONE);
		endcase
	endfunction

	// favor the image border, where sweeps fall off the detector
	function automatic int pick_coord();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? GRID - 1 : 0;
		return $urandom_range(GRID - 1);
	endfunction

	task automatic wait_drained();
		while (!(words_accepted == words_queued && expected_sums.size() == 0))
			@(posedge clk);
	endtask

	task automatic queue_mixed_traffic(input int target);
		int count, pick, k, j;
		bit sweep;
		count = 0;
		while (count < target) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				// partial column update, sometimes closed by a sweep
				k = $urandom_range(1, 8);
				sweep = ($urandom_range(3) == 0);
				for (j = 0; j < k; j++)
					queue_word(ACT_LOAD, $urandom_range(255), $urandom_range(GRID - 1),
						pick_sample(), sweep && j == k - 1, pick_coord(), pick_coord());
				count += k;
			end else if (pick < 85) begin
				k = $urandom_range(1, 4);
				for (j = 0; j < k; j++)
					queue_word(ACT_READ, $urandom_range(255), $urandom_range(GRID - 1),
						pick_sample(), 1'($urandom_range(1)), pick_coord(), pick_coord());
				count += k;
			end else if (pick < 89) begin
				queue_word(ACT_CLEAR, $urandom_range(255), $urandom_range(GRID - 1),
					pick_sample(), 1'($urandom_range(1)), pick_coord(), pick_coord());
				count++;
			end else if (pick < 95) begin
				queue_word(ACT_IGNORED, $urandom_range(255), $urandom_range(GRID - 1),
					pick_sample(), 1'($urandom_range(1)), pick_coord(), pick_coord());
				count++;
			end else begin
				// column update broken up by a read
				queue_word(ACT_LOAD, $urandom_range(255), $urandom_range(GRID - 1),
					pick_sample(), 1'b0, pick_coord(), pick_coord());
				queue_word(ACT_READ, $urandom_range(255), $urandom_range(GRID - 1),
					pick_sample(), 1'b1, pick_coord(), pick_coord());
				queue_word(ACT_LOAD, $urandom_range(255), $urandom_range(GRID - 1),
					pick_sample(), 1'b1, pick_coord(), pick_coord());
				count += 3;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic [IN_TDATA_W-1:0] payload;
		bp_word_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_to_image(offered);
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_words.pop_front();
					payload = '0;
					payload[ANGLE_LSB +: ANGLE_W] = nxt.angle;
					payload[DET_LSB +: DET_W] = nxt.det;
					payload[SAMPLE_LSB +: SAMPLE_W] = nxt.sample;
					payload[PX_LSB +: PIX_W] = nxt.px;
					payload[PY_LSB +: PIX_W] = nxt.py;
					offered <= nxt;
					s_tdata <= payload;
					s_tuser <= nxt.action;
					s_tlast <= nxt.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [SUM_W-1:0] want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch("result word with no read pending", m_tdata[SUM_W-1:0], '0);
				end else begin
					want = expected_sums.pop_front();
					if (m_tdata[SUM_W-1:0] !== want)
						report_mismatch("wrong pixel sum", m_tdata[SUM_W-1:0], want);
				end
			end
			// long hold-off lets the block back up into its input
			if (holds_served != hold_requests) begin
				holds_served <= holds_served + 1;
				hold_left <= HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycles_run <= cycles_run + 1;
		if (cycles_run == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int k, quad, rem, s, c, d;
		longint unsigned ang;

		for (k = 0; k < ANGLES; k++) begin
			quad = (4 * k) / ANGLES;
			rem = 4 * k - quad * ANGLES;
			ang = rem;
			ang = (ang * HALF_PI_Q30) / ANGLES;
			s = round_to_q14(quarter_sine_q30(ang));
			c = round_to_q14(quarter_sine_q30(HALF_PI_Q30 - ang));
			// fold the quadrant back by symmetry
			case (quad % 4)
				0: begin sin_q14[k] = s;  cos_q14[k] = c;  end
				1: begin sin_q14[k] = c;  cos_q14[k] = -s; end
				2: begin sin_q14[k] = -s; cos_q14[k] = -c; end
				default: begin sin_q14[k] = -c; cos_q14[k] = s; end
			endcase
		end
		for (k = 0; k < GRID; k++)
			detector_bins[k] = 0;
		for (k = 0; k < GRID * GRID; k++)
			image_sums[k] = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 26;
		recv_idle_pct = 67;

		// fresh image, ignored fields at their extremes
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, 0);
		queue_word(ACT_READ, 255, GRID - 1, SAMPLE_ONE, 1'b1, GRID - 1, GRID - 1);
		queue_word(ACT_IGNORED, 255, GRID - 1, SAMPLE_ONE, 1'b1, GRID - 1, GRID - 1);
		queue_word(ACT_CLEAR, 0, 0, 0, 1'b0, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 17, 42);

		// fill every detector bin before the first sweep
		for (d = 0; d < GRID; d++)
			queue_word(ACT_LOAD, 0, d,
				(d == 0) ? 0 : (d == GRID - 1) ? SAMPLE_ONE : pick_sample(),
				d == GRID - 1, pick_coord(), pick_coord());
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID - 1, GRID - 1);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID / 2, GRID / 2);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, GRID - 1);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID - 1, 0);

		// sweeps at the quadrant boundaries, the last table entry and wrapped angle codes
		for (k = 1; k <= 5; k++) begin
			queue_word(ACT_LOAD, 45 * k, $urandom_range(GRID - 1), pick_sample(), 1'b1, 0, 0);
			queue_word(ACT_READ, 0, 0, 0, 1'b0, pick_coord(), pick_coord());
		end
		queue_word(ACT_LOAD, ANGLES - 1, 0, SAMPLE_ONE, 1'b1, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID - 1, 0);
		queue_word(ACT_LOAD, ANGLE_CODES - 1, GRID - 1, 0, 1'b1, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, GRID - 1);
		wait_drained();

		hold_requests <= hold_requests + 1;
		@(posedge clk);
		for (k = 0; k < 12; k++)
			queue_word(ACT_READ, 0, 0, 0, 1'b0, pick_coord(), pick_coord());
		wait_drained();

		queue_mixed_traffic(80);
		wait_drained();

		send_idle_pct = 67;
		recv_idle_pct = 26;

		// 256 full-scale sweeps drive the covered pixels into saturation
		for (d = 0; d < GRID; d++)
			queue_word(ACT_LOAD, $urandom_range(255), d, SAMPLE_ONE, d == GRID - 1,
				pick_coord(), pick_coord());
		for (k = 1; k < 256; k++) begin
			queue_word(ACT_LOAD, $urandom_range(255), $urandom_range(GRID - 1), SAMPLE_ONE,
				1'b1, pick_coord(), pick_coord());
			if (k % 32 == 0)
				queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID / 2, GRID / 2);
		end
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID / 2, GRID / 2);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID / 2 - 1, GRID / 2);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID - 1, GRID - 1);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, 0, GRID - 1);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID - 1, 0);
		for (k = 0; k < 4; k++)
			queue_word(ACT_READ, 0, 0, 0, 1'b0, pick_coord(), pick_coord());
		queue_word(ACT_CLEAR, 0, 0, 0, 1'b0, 0, 0);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, GRID / 2, GRID / 2);
		queue_word(ACT_READ, 0, 0, 0, 1'b0, pick_coord(), pick_coord());
		wait_drained();

		queue_mixed_traffic(80);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_mixed_traffic(100);
		wait_drained();

		// let a trailing sweep or clear run out
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
